/* src/timed_access_code_table_top_defines.svh */
// Assertion macros for the timed access code table.
`ifndef TIMED_ACCESS_CODE_TABLE_TOP_DEFINES_SVH
`define TIMED_ACCESS_CODE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TACT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tact assertion failed");

// Next-cycle implication, disabled during reset.
`define TACT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tact assertion failed");

`endif

/* src/tact_pkg.sv */
// Package: constants, codes and types of the timed access code table.
package tact_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int CODE_CHARS  = 8;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam logic [31:0] SYNC_LIMIT = 32'd1000000;

	typedef enum logic [2:0] {
		REQ_CREATE  = 3'd0,
		REQ_UPDATE  = 3'd1,
		REQ_DELETE  = 3'd2,
		REQ_VALID   = 3'd3,
		REQ_CLEANUP = 3'd4,
		REQ_CLEAR   = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ST_DONE       = 3'd0,
		ST_NOT_FOUND  = 3'd1,
		ST_FULL       = 3'd2,
		ST_MASTER     = 3'd3,
		ST_ENTRY      = 3'd4,
		ST_NO_MATCH   = 3'd5,
		ST_NOT_SYNCED = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_RD,
		S_EV,
		S_POST
	} fsm_state_t;

	typedef struct packed {
		logic [15:0] ent_id;
		logic [63:0] ent_code;
		logic [31:0] ent_start;
		logic [31:0] ent_stop;
	} entry_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic rd;
		logic eval;
		logic post;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic walk_needed;
		logic stop;
	} dp_st_t;

	// Mask of the code bytes that take part in compares.
	function automatic logic [63:0] code_mask();
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (i < CODE_CHARS) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

/* src/tact_ctrl.sv */
// Controller state machine: sequences the walk over the table and the result hand-off.
module tact_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  tact_pkg::dp_st_t st,
	output tact_pkg::cmd_t  cmd
);
	import tact_pkg::*;

	fsm_state_t state_q, state_d;
	logic       out_valid_q;
	logic       fire;

	// State register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign fire      = (state_q == S_POST) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				state_d = st.walk_needed ? S_RD : S_POST;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EV;
			end
			S_EV: begin
				cmd.eval = 1'b1;
				state_d  = st.stop ? S_POST : S_RD;
			end
			S_POST: begin
				cmd.post = fire;
				if (fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* src/tact_dp.sv */
// Datapath: request registers, entry memory, compare logic and result registers.
module tact_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [63:0]     cfg_wdata,
	input  logic [2:0]      req_type,
	input  logic [15:0]     entry_id,
	input  logic [63:0]     code_chars,
	input  logic [31:0]     window_start,
	input  logic [31:0]     window_end,
	input  logic [31:0]     now_time,
	input  tact_pkg::cmd_t  cmd,
	output tact_pkg::dp_st_t st,
	output logic [2:0]      status,
	output logic [15:0]     matched_id,
	output logic [4:0]      entries_held
);
	import tact_pkg::*;

	entry_t           mem [MAX_ENTRIES];
	entry_t           rd_data_q;
	logic [63:0]      master_q;
	logic [2:0]       req_q;
	logic [15:0]      id_q;
	logic [63:0]      code_q;
	logic [31:0]      start_q, stop_q, now_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] rd_i_q;
	logic [CNT_W-1:0] wr_k_q;
	logic             found_q;
	logic [IDX_W-1:0] pos_q;
	logic [15:0]      match_q;
	logic [2:0]       status_q;
	logic [15:0]      matched_q;

	logic             synced, master_hit, is_search, is_comp, hit, keep, last;
	logic             id_eq, val_hit;
	logic             we;
	logic [IDX_W-1:0] wa;
	entry_t           wd, new_ent;
	logic [2:0]       status_d;
	logic [CNT_W-1:0] count_d;

	assign synced     = (now_q >= SYNC_LIMIT);
	assign master_hit = (code_q == (master_q & code_mask()));
	assign is_search  = (req_q == REQ_CREATE) || (req_q == REQ_UPDATE) || (req_q == REQ_VALID);
	assign is_comp    = (req_q == REQ_DELETE) || (req_q == REQ_CLEANUP);

	// Compare the entry just read
	assign id_eq   = (rd_data_q.ent_id == id_q);
	assign val_hit = (rd_data_q.ent_code == code_q) && (now_q >= rd_data_q.ent_start)
		&& (now_q <= rd_data_q.ent_stop);
	assign hit     = (req_q == REQ_VALID) ? val_hit : id_eq;
	assign keep    = (req_q == REQ_DELETE) ? !(id_eq && !found_q)
		: (rd_data_q.ent_stop >= now_q);
	assign last    = (CNT_W'(rd_i_q) == count_q - CNT_W'(1));

	assign st.walk_needed = (count_q != '0) && (
		(req_q == REQ_CREATE) || (req_q == REQ_UPDATE) || (req_q == REQ_DELETE) ||
		((req_q == REQ_VALID) && !master_hit && synced) ||
		((req_q == REQ_CLEANUP) && synced));
	assign st.stop = (is_search && hit) || last;

	assign new_ent = '{ent_id: id_q, ent_code: code_q, ent_start: start_q, ent_stop: stop_q};

	// Outcome of the request and memory write selection
	always_comb begin
		status_d = ST_DONE;
		count_d  = count_q;
		we       = 1'b0;
		wa       = pos_q;
		wd       = new_ent;
		if (cmd.eval) begin
			if (is_comp && keep) begin
				we = 1'b1;
				wa = wr_k_q[IDX_W-1:0];
				wd = rd_data_q;
			end
		end else if (cmd.post) begin
			case (req_q)
				REQ_CREATE: begin
					if (found_q) begin
						we = 1'b1;
					end else if (count_q >= CNT_W'(MAX_ENTRIES)) begin
						status_d = ST_FULL;
					end else begin
						we      = 1'b1;
						wa      = count_q[IDX_W-1:0];
						count_d = count_q + CNT_W'(1);
					end
				end
				REQ_UPDATE: begin
					if (found_q) begin
						we = 1'b1;
					end else begin
						status_d = ST_NOT_FOUND;
					end
				end
				REQ_DELETE: begin
					if (found_q) begin
						count_d = wr_k_q;
					end else begin
						status_d = ST_NOT_FOUND;
					end
				end
				REQ_VALID: begin
					if (master_hit) begin
						status_d = ST_MASTER;
					end else if (!synced) begin
						status_d = ST_NOT_SYNCED;
					end else if (found_q) begin
						status_d = ST_ENTRY;
					end else begin
						status_d = ST_NO_MATCH;
					end
				end
				REQ_CLEANUP: begin
					if (!synced) begin
						status_d = ST_NOT_SYNCED;
					end else begin
						count_d = wr_k_q;
					end
				end
				REQ_CLEAR: count_d = '0;
				default: status_d = ST_DONE;
			endcase
		end
	end

	// Entry memory: one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[rd_i_q];
		end
	end

	// Hold the request fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			id_q    <= entry_id;
			code_q  <= code_chars & code_mask();
			start_q <= window_start;
			stop_q  <= window_end;
			now_q   <= now_time;
		end
	end

	// Walk pointers, search result and table count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q  <= '0;
			count_q   <= '0;
			rd_i_q    <= '0;
			wr_k_q    <= '0;
			found_q   <= 1'b0;
			pos_q     <= '0;
			match_q   <= '0;
			status_q  <= ST_DONE;
			matched_q <= '0;
		end else begin
			if (cfg_we) begin
				master_q <= cfg_wdata;
			end
			if (cmd.load) begin
				rd_i_q  <= '0;
				wr_k_q  <= '0;
				found_q <= 1'b0;
				match_q <= '0;
			end
			if (cmd.eval) begin
				rd_i_q <= rd_i_q + IDX_W'(1);
				if (is_search && hit) begin
					found_q <= 1'b1;
					pos_q   <= rd_i_q;
					match_q <= rd_data_q.ent_id;
				end
				if (is_comp) begin
					if (keep) begin
						wr_k_q <= wr_k_q + CNT_W'(1);
					end else begin
						found_q <= 1'b1;
					end
				end
			end
			if (cmd.post) begin
				count_q   <= count_d;
				status_q  <= status_d;
				matched_q <= (status_d == ST_ENTRY) ? match_q : 16'd0;
			end
		end
	end

	assign status       = status_q;
	assign matched_id   = matched_q;
	assign entries_held = 5'(count_q);

endmodule

/* src/timed_access_code_table_top.sv */
// Top level of the timed access code table.
// One request at a time: a request goes from idle through the start state to the post
// state when no table walk is needed, and walks N stored entries with a read and an
// evaluate state per entry: one for the registered memory read and one to compare
// and, for delete and cleanup, write it back in compacted order. The next
// request is taken as soon as the previous result sits in the output register.
module timed_access_code_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] entry_id,
	input  logic [63:0] code_chars,
	input  logic [31:0] window_start,
	input  logic [31:0] window_end,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] matched_id,
	output logic [4:0]  entries_held
);
	import tact_pkg::*;

	`include "timed_access_code_table_top_defines.svh"

	cmd_t   cmd;
	dp_st_t st;

	tact_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	tact_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_type     (req_type),
		.entry_id     (entry_id),
		.code_chars   (code_chars),
		.window_start (window_start),
		.window_end   (window_end),
		.now_time     (now_time),
		.cmd          (cmd),
		.st           (st),
		.status       (status),
		.matched_id   (matched_id),
		.entries_held (entries_held)
	);

	// Checks on the controller and result
	`TACT_ASSERT_SAME(a_count_range, out_valid, entries_held <= 5'(MAX_ENTRIES))
	`TACT_ASSERT_SAME(a_id_only_on_match, out_valid && (status != ST_ENTRY), matched_id == 16'd0)
	`TACT_ASSERT_SAME(a_busy_while_walk, cmd.rd || cmd.eval || cmd.post, in_stall)
	`TACT_ASSERT_NEXT(a_busy_after_load, cmd.load, in_stall)

endmodule
